// ===== src/bpe_pts_pkg.sv =====
// Shared types and constants for the pre-tokeniser splitter.
package bpe_pts_pkg;

  typedef enum logic [1:0] {K_SP, K_L, K_N, K_O} kind_t;

  // Classified character as it travels from front to back.
  typedef struct packed {
    kind_t      kind;
    logic       nl;
    logic       blank;
    logic       apos;
    logic       stmd;    // lowered code is s, t, m or d
    logic       rvl;     // lowered code is r, v or l
    logic       lc_l;    // lowered code is l
    logic       lc_e;    // lowered code is e
    logic [2:0] nbytes;
  } char_cls_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } piece_t;

  // Back-to-output-queue control.
  typedef struct packed {
    logic [1:0] n;
    logic       mark_prev;
    logic       hold;
  } push_ctl_t;

  localparam logic MODE_GPT4 = 1'b1;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
  localparam int MAX_PUSH = 3;

  localparam logic [20:0] CP_TAB   = 21'h09;
  localparam logic [20:0] CP_LF    = 21'h0A;
  localparam logic [20:0] CP_CR    = 21'h0D;
  localparam logic [20:0] CP_SP    = 21'h20;
  localparam logic [20:0] CP_APOS  = 21'h27;
  localparam logic [20:0] CP_NEL   = 21'h85;
  localparam logic [20:0] CP_NBSP  = 21'hA0;
  localparam logic [20:0] CP_ENQ   = 21'h2000;
  localparam logic [20:0] CP_HAIR  = 21'h200A;
  localparam logic [20:0] CP_LSEP  = 21'h2028;
  localparam logic [20:0] CP_PSEP  = 21'h2029;
  localparam logic [20:0] CP_NNBSP = 21'h202F;
  localparam logic [20:0] CP_MMSP  = 21'h205F;
  localparam logic [20:0] CP_IDSP  = 21'h3000;
  localparam logic [20:0] CP_UC_A  = 21'h41;
  localparam logic [20:0] CP_UC_Z  = 21'h5A;
  localparam logic [20:0] CASE_OFS = 21'h20;
  localparam logic [20:0] CH_S     = 21'h73;
  localparam logic [20:0] CH_T     = 21'h74;
  localparam logic [20:0] CH_M     = 21'h6D;
  localparam logic [20:0] CH_D     = 21'h64;
  localparam logic [20:0] CH_R     = 21'h72;
  localparam logic [20:0] CH_V     = 21'h76;
  localparam logic [20:0] CH_L     = 21'h6C;
  localparam logic [20:0] CH_E     = 21'h65;

  function automatic logic ws_code(input logic [20:0] c);
    return (c == CP_SP) || (c >= CP_TAB && c <= CP_CR) || (c == CP_NEL) ||
           (c == CP_NBSP) || (c >= CP_ENQ && c <= CP_HAIR) || (c == CP_LSEP) ||
           (c == CP_PSEP) || (c == CP_NNBSP) || (c == CP_MMSP) || (c == CP_IDSP);
  endfunction

endpackage

// ===== src/bpe_pts_front.sv =====
// Front end: accepts characters, tracks byte offset, classifies, queues.
module bpe_pts_front import bpe_pts_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mode,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [20:0]            in_code_point,
  input  logic [2:0]             in_char_bytes,
  input  logic                   in_char_valid,
  input  logic                   in_is_letter_flag,
  input  logic                   in_is_number_flag,
  input  logic                   in_end_of_text,
  output logic                   fq_valid,
  input  logic                   fq_pop,
  output char_cls_t              fq_cls,
  output logic [OFFSET_BITS-1:0] fq_pos,
  output logic                   fq_eot
);

  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  char_cls_t              q_cls_r [FQ_DEPTH];
  logic [OFFSET_BITS-1:0] q_pos_r [FQ_DEPTH];
  logic                   q_eot_r [FQ_DEPTH];
  logic [FQ_AW-1:0]       wptr_r, rptr_r;
  logic [FQ_CW-1:0]       cnt_r, cnt_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic                   acc;
  logic [20:0]            lc;
  logic                   sp;
  char_cls_t              cls;

  assign in_ready = (cnt_r != FQ_CW'(FQ_DEPTH));
  assign acc      = in_valid && in_ready;
  assign fq_valid = (cnt_r != '0);
  assign fq_cls   = q_cls_r[rptr_r];
  assign fq_pos   = q_pos_r[rptr_r];
  assign fq_eot   = q_eot_r[rptr_r];

  always_comb begin
    lc = in_code_point;
    if (mode == MODE_GPT4 && in_code_point >= CP_UC_A && in_code_point <= CP_UC_Z) begin
      lc = in_code_point + CASE_OFS;
    end
    sp = in_char_valid && ws_code(in_code_point);
    if (!in_char_valid)          cls.kind = K_O;
    else if (sp)                 cls.kind = K_SP;
    else if (in_is_letter_flag)  cls.kind = K_L;
    else if (in_is_number_flag)  cls.kind = K_N;
    else                         cls.kind = K_O;
    cls.nl     = in_char_valid && (in_code_point == CP_LF || in_code_point == CP_CR);
    cls.blank  = in_char_valid && (in_code_point == CP_SP);
    cls.apos   = in_char_valid && (in_code_point == CP_APOS);
    cls.stmd   = in_char_valid && (lc == CH_S || lc == CH_T || lc == CH_M || lc == CH_D);
    cls.rvl    = in_char_valid && (lc == CH_R || lc == CH_V || lc == CH_L);
    cls.lc_l   = in_char_valid && (lc == CH_L);
    cls.lc_e   = in_char_valid && (lc == CH_E);
    cls.nbytes = in_char_bytes;
  end

  always_comb begin
    cnt_nxt = cnt_r + FQ_CW'(acc) - FQ_CW'(fq_pop);
    pos_nxt = pos_r;
    if (acc) begin
      pos_nxt = in_end_of_text ? '0 : pos_r + OFFSET_BITS'(in_char_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      pos_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      if (acc)    wptr_r <= wptr_r + 1'b1;
      if (fq_pop) rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_cls_r[wptr_r] <= cls;
      q_pos_r[wptr_r] <= pos_r;
      q_eot_r[wptr_r] <= in_end_of_text;
    end
  end

endmodule

// ===== src/bpe_pts_back.sv =====
// Back end: split-rule matcher, one character per cycle while the output queue has room, with replay.
module bpe_pts_back import bpe_pts_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mode,
  input  logic                   fq_valid,
  input  char_cls_t              fq_cls,
  input  logic [OFFSET_BITS-1:0] fq_pos,
  input  logic                   fq_eot,
  output logic                   fq_pop,
  input  logic [OQ_CW-1:0]       oq_count,
  output piece_t [MAX_PUSH-1:0]  em_pieces,
  output push_ctl_t              em_ctl
);

  localparam int PW = OFFSET_BITS;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CQ1, PH_CQ2, PH_LRUN, PH_NRUN, PH_OFIRST, PH_ORUN, PH_NLTAIL,
    PH_WSBLANK, PH_WSSPACE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [PW-1:0]   ops_r, ops_nxt;
  logic [PW-1:0]   srs_r, srs_nxt;
  logic [PW-1:0]   lscs_r, lscs_nxt;
  logic [PW-1:0]   lne_r, lne_nxt;
  logic            nls_r, nls_nxt;
  logic [1:0]      dcnt_r, dcnt_nxt;
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [2:0]      pend0_nb_r, pend0_nb_nxt;
  char_cls_t       pend1_r, pend1_nxt;
  char_cls_t       rq_cls_r [2];
  logic [PW-1:0]   rq_pos_r [2];
  logic [1:0]      rq_cnt_r, rq_cnt_nxt;
  logic            fin_r, fin_nxt;
  logic [PW-1:0]   txt_end_r, txt_end_nxt;
  logic            cur_emit_r, cur_emit_nxt;

  logic            g4, from_rq, can_run, op_char, op_fin, do_start;
  char_cls_t       ch;
  logic [PW-1:0]   p, e, r, sp1_pos;
  phase_t          o_phase;
  logic [1:0]      em_n, ld_n;
  char_cls_t       ld_cls0, ld_cls1;
  logic [PW-1:0]   ld_pos0, ld_pos1;
  logic            mark_prev;

  function automatic piece_t mk_piece(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW-1:0] d;
    logic [63:0]   aw, dw;
    piece_t        pc;
    d        = b - a;
    aw       = 64'(a);
    dw       = 64'(d);
    pc.start = aw[31:0];
    pc.len   = dw[31:0];
    pc.last  = 1'b0;
    return pc;
  endfunction

  always_comb begin
    g4      = (mode == MODE_GPT4);
    from_rq = (rq_cnt_r != 2'd0);
    ch      = from_rq ? rq_cls_r[0] : fq_cls;
    p       = from_rq ? rq_pos_r[0] : fq_pos;
    e       = p + PW'(ch.nbytes);
    sp1_pos = ops_r + PW'(pend0_nb_r);
    o_phase = g4 ? PH_OFIRST : PH_ORUN;
    can_run = (oq_count <= OQ_CW'(OQ_DEPTH - MAX_PUSH));
    op_char = can_run && (from_rq || (!fin_r && fq_valid));
    op_fin  = can_run && !from_rq && fin_r;
    fq_pop  = can_run && !from_rq && !fin_r && fq_valid;

    phase_nxt    = phase_r;
    ops_nxt      = ops_r;
    srs_nxt      = srs_r;
    lscs_nxt     = lscs_r;
    lne_nxt      = lne_r;
    nls_nxt      = nls_r;
    dcnt_nxt     = dcnt_r;
    pcnt_nxt     = pcnt_r;
    pend0_nb_nxt = pend0_nb_r;
    pend1_nxt    = pend1_r;
    rq_cnt_nxt   = rq_cnt_r;
    fin_nxt      = fin_r;
    txt_end_nxt  = txt_end_r;
    cur_emit_nxt = cur_emit_r;
    em_pieces    = '0;
    em_n         = 2'd0;
    do_start     = 1'b0;
    ld_n         = 2'd0;
    ld_cls0      = pend1_r;
    ld_pos0      = sp1_pos;
    ld_cls1      = ch;
    ld_pos1      = p;
    mark_prev    = 1'b0;
    r            = srs_r;

    if (op_char) begin
      case (phase_r)
        PH_CQ1: begin
          if (ch.stmd) begin
            em_pieces[em_n] = mk_piece(ops_r, e); em_n = em_n + 2'd1;
            pcnt_nxt  = 2'd0;
            phase_nxt = PH_IDLE;
          end else if (ch.rvl) begin
            pend1_nxt = ch;
            pcnt_nxt  = 2'd2;
            phase_nxt = PH_CQ2;
          end else begin
            // failed contraction: reread this character as part of an other-run
            pcnt_nxt  = 2'd0;
            phase_nxt = o_phase;
            ld_n      = 2'd1;
            ld_cls0   = ch;
            ld_pos0   = p;
          end
        end
        PH_CQ2: begin
          if ((pend1_r.lc_l && ch.lc_l) || (!pend1_r.lc_l && ch.lc_e)) begin
            em_pieces[em_n] = mk_piece(ops_r, e); em_n = em_n + 2'd1;
            pcnt_nxt  = 2'd0;
            phase_nxt = PH_IDLE;
          end else begin
            pcnt_nxt  = 2'd0;
            phase_nxt = o_phase;
            ld_n      = 2'd2;
          end
        end
        PH_LRUN: begin
          if (ch.kind != K_L) begin
            em_pieces[em_n] = mk_piece(ops_r, p); em_n = em_n + 2'd1;
            do_start = 1'b1;
          end
        end
        PH_NRUN: begin
          if (ch.kind == K_N) begin
            if (g4 && dcnt_r == 2'd3) begin
              em_pieces[em_n] = mk_piece(ops_r, p); em_n = em_n + 2'd1;
              ops_nxt  = p;
              dcnt_nxt = 2'd1;
            end else if (dcnt_r != 2'd3) begin
              dcnt_nxt = dcnt_r + 2'd1;
            end
          end else begin
            em_pieces[em_n] = mk_piece(ops_r, p); em_n = em_n + 2'd1;
            do_start = 1'b1;
          end
        end
        PH_OFIRST, PH_ORUN: begin
          if (g4 && phase_r == PH_OFIRST && ch.kind == K_L) begin
            phase_nxt = PH_LRUN;
          end else if (ch.kind == K_O) begin
            phase_nxt = PH_ORUN;
          end else if (g4 && ch.nl) begin
            phase_nxt = PH_NLTAIL;
          end else begin
            em_pieces[em_n] = mk_piece(ops_r, p); em_n = em_n + 2'd1;
            do_start = 1'b1;
          end
        end
        PH_NLTAIL: begin
          if (!ch.nl) begin
            em_pieces[em_n] = mk_piece(ops_r, p); em_n = em_n + 2'd1;
            do_start = 1'b1;
          end
        end
        PH_WSBLANK, PH_WSSPACE: begin
          if (ch.kind == K_SP) begin
            lscs_nxt = p;
            if (ch.nl) begin
              nls_nxt = 1'b1;
              lne_nxt = e;
            end
            phase_nxt = ch.blank ? PH_WSBLANK : PH_WSSPACE;
          end else begin
            // run closes: newline part, body, then last space char
            if (g4 && nls_r) begin
              em_pieces[em_n] = mk_piece(srs_r, lne_r); em_n = em_n + 2'd1;
              r = lne_r;
            end
            if (r == p) begin
              do_start = 1'b1;
            end else begin
              if (r != lscs_r) begin
                em_pieces[em_n] = mk_piece(r, lscs_r); em_n = em_n + 2'd1;
              end
              if (g4 && ch.kind == K_L) begin
                ops_nxt   = lscs_r;
                phase_nxt = PH_LRUN;
              end else if (g4 && phase_r == PH_WSBLANK && ch.kind == K_O) begin
                ops_nxt   = lscs_r;
                phase_nxt = PH_ORUN;
              end else if (!g4 && phase_r == PH_WSBLANK) begin
                ops_nxt = lscs_r;
                if (ch.kind == K_L) begin
                  phase_nxt = PH_LRUN;
                end else if (ch.kind == K_N) begin
                  phase_nxt = PH_NRUN;
                  dcnt_nxt  = 2'd1;
                end else begin
                  phase_nxt = PH_ORUN;
                end
              end else begin
                em_pieces[em_n] = mk_piece(lscs_r, p); em_n = em_n + 2'd1;
                do_start = 1'b1;
              end
            end
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase

      if (do_start) begin
        ops_nxt = p;
        if (ch.apos) begin
          pend0_nb_nxt = ch.nbytes;
          pcnt_nxt     = 2'd1;
          phase_nxt    = PH_CQ1;
        end else begin
          case (ch.kind)
            K_L: phase_nxt = PH_LRUN;
            K_N: begin
              phase_nxt = PH_NRUN;
              dcnt_nxt  = 2'd1;
            end
            K_SP: begin
              srs_nxt   = p;
              lscs_nxt  = p;
              nls_nxt   = ch.nl;
              lne_nxt   = ch.nl ? e : '0;
              phase_nxt = ch.blank ? PH_WSBLANK : PH_WSSPACE;
            end
            default: phase_nxt = o_phase;
          endcase
        end
      end

      if (from_rq) begin
        rq_cnt_nxt = rq_cnt_r - 2'd1;
      end
      if (fq_pop) begin
        fin_nxt      = fq_eot;
        txt_end_nxt  = e;
        cur_emit_nxt = (em_n != 2'd0);
      end else begin
        cur_emit_nxt = cur_emit_r || (em_n != 2'd0);
      end
    end else if (op_fin) begin
      if (phase_r == PH_CQ1 || phase_r == PH_CQ2) begin
        // contraction cut off by end of text
        phase_nxt = o_phase;
        pcnt_nxt  = 2'd0;
        if (pcnt_r == 2'd2) ld_n = 2'd1;
      end else begin
        case (phase_r)
          PH_IDLE: ;
          PH_WSBLANK, PH_WSSPACE: begin
            if (g4 && nls_r) begin
              em_pieces[em_n] = mk_piece(srs_r, lne_r); em_n = em_n + 2'd1;
              if (lne_r != txt_end_r) begin
                em_pieces[em_n] = mk_piece(lne_r, txt_end_r); em_n = em_n + 2'd1;
              end
            end else begin
              em_pieces[em_n] = mk_piece(srs_r, txt_end_r); em_n = em_n + 2'd1;
            end
          end
          default: begin
            em_pieces[em_n] = mk_piece(ops_r, txt_end_r); em_n = em_n + 2'd1;
          end
        endcase
        if (em_n != 2'd0) begin
          em_pieces[em_n - 2'd1].last = 1'b1;
        end else begin
          mark_prev = cur_emit_r;
        end
        phase_nxt    = PH_IDLE;
        ops_nxt      = '0;
        srs_nxt      = '0;
        lscs_nxt     = '0;
        lne_nxt      = '0;
        nls_nxt      = 1'b0;
        dcnt_nxt     = 2'd0;
        pcnt_nxt     = 2'd0;
        fin_nxt      = 1'b0;
        cur_emit_nxt = 1'b0;
      end
    end

    if (ld_n != 2'd0) begin
      rq_cnt_nxt = ld_n;
    end

    em_ctl.n         = em_n;
    em_ctl.mark_prev = mark_prev;
    em_ctl.hold      = fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      ops_r      <= '0;
      srs_r      <= '0;
      lscs_r     <= '0;
      lne_r      <= '0;
      nls_r      <= 1'b0;
      dcnt_r     <= 2'd0;
      pcnt_r     <= 2'd0;
      rq_cnt_r   <= 2'd0;
      fin_r      <= 1'b0;
      cur_emit_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      ops_r      <= ops_nxt;
      srs_r      <= srs_nxt;
      lscs_r     <= lscs_nxt;
      lne_r      <= lne_nxt;
      nls_r      <= nls_nxt;
      dcnt_r     <= dcnt_nxt;
      pcnt_r     <= pcnt_nxt;
      rq_cnt_r   <= rq_cnt_nxt;
      fin_r      <= fin_nxt;
      cur_emit_r <= cur_emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend0_nb_r <= pend0_nb_nxt;
    pend1_r    <= pend1_nxt;
    txt_end_r  <= txt_end_nxt;
    if (ld_n != 2'd0) begin
      rq_cls_r[0] <= ld_cls0;
      rq_pos_r[0] <= ld_pos0;
      rq_cls_r[1] <= ld_cls1;
      rq_pos_r[1] <= ld_pos1;
    end else if (op_char && from_rq) begin
      rq_cls_r[0] <= rq_cls_r[1];
      rq_pos_r[0] <= rq_pos_r[1];
    end
  end

`ifndef ASSERT_OFF
  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r != 2'd3)
    else $error("replay queue overfilled");
  a_pop_no_replay: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> (rq_cnt_r == 2'd0 && !fin_r))
    else $error("new character taken while replay or end of text pending");
  a_fin_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (op_fin && phase_r != PH_CQ1 && phase_r != PH_CQ2) |=>
      (phase_r == PH_IDLE && !fin_r && pcnt_r == 2'd0))
    else $error("end of text did not return matcher to idle");
`endif

endmodule

// ===== src/bpe_pts_outq.sv =====
// Output queue: takes up to three pieces a cycle, delivers one a cycle while out_ready is high.
module bpe_pts_outq import bpe_pts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  piece_t [MAX_PUSH-1:0] em_pieces,
  input  push_ctl_t             em_ctl,
  output logic [OQ_CW-1:0]      oq_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_piece_start,
  output logic [31:0]           out_piece_length,
  output logic                  out_last_piece
);

  piece_t           ent_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wptr_r, rptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic             pop;

  // youngest piece waits while its text may still mark it last
  assign out_valid        = (cnt_r > OQ_CW'(1)) || (cnt_r == OQ_CW'(1) && !em_ctl.hold);
  assign pop              = out_valid && out_ready;
  assign oq_count         = cnt_r;
  assign out_piece_start  = ent_r[rptr_r].start;
  assign out_piece_length = ent_r[rptr_r].len;
  assign out_last_piece   = ent_r[rptr_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + OQ_AW'(em_ctl.n);
      rptr_r <= rptr_r + OQ_AW'(pop);
      cnt_r  <= cnt_r + OQ_CW'(em_ctl.n) - OQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (em_ctl.mark_prev) begin
      ent_r[wptr_r - 1'b1].last <= 1'b1;
    end
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (2'(i) < em_ctl.n) begin
        ent_r[wptr_r + OQ_AW'(i)] <= em_pieces[i];
      end
    end
  end

endmodule

// ===== src/bpe_pretokenize_splitter_core.sv =====
// Top level of the streaming GPT-2 / GPT-4 pre-tokeniser splitter.
//
// Input channel (in_valid / in_ready): one decoded character per request,
// with code point, UTF-8 byte count, validity and letter/number flags and an
// end-of-text marker on the final character of a text.
// Output channel (out_valid / out_ready): one piece per request, as byte
// offset and byte length, last_piece set on the final piece of a text.
// APB port: register 0 bit 0 selects GPT-4 rules (1) or GPT-2 rules (0);
// write it only while the block is idle. pready is tied high.
// Throughput: one character per cycle through the match unit while the output
// queue has room. A failed apostrophe contraction rereads one or two
// characters; end of text is a step of its own. Pieces leave at one per cycle
// while out_ready is high, so dense short pieces pace the output.
// A piece closed by a character passes the input queue, the match unit and
// the output queue before it can be taken. A text's final piece is held
// until its end-of-text flag is resolved.
// Reset (rst_n, synchronous) empties both queues, zeroes the byte offset
// and selects GPT-2 rules. When out_ready is low the output queue fills; the
// match unit stops with fewer than three free slots and the input queue then
// drops in_ready.
module bpe_pretokenize_splitter_core import bpe_pts_pkg::*; #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [20:0] in_code_point,
  input  logic [2:0]  in_char_bytes,
  input  logic        in_char_valid,
  input  logic        in_is_letter_flag,
  input  logic        in_is_number_flag,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_piece_start,
  output logic [31:0] out_piece_length,
  output logic        out_last_piece
);

  logic                   split_mode_r;
  logic                   fq_valid, fq_pop, fq_eot;
  char_cls_t              fq_cls;
  logic [OFFSET_BITS-1:0] fq_pos;
  logic [OQ_CW-1:0]       oq_count;
  piece_t [MAX_PUSH-1:0]  em_pieces;
  push_ctl_t              em_ctl;

  // Single register; every word address decodes to it.
  assign pready = 1'b1;
  assign prdata = {31'd0, split_mode_r} | {30'd0, paddr & 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      split_mode_r <= pwdata[0];
    end
  end

  bpe_pts_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .mode              (split_mode_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_code_point     (in_code_point),
    .in_char_bytes     (in_char_bytes),
    .in_char_valid     (in_char_valid),
    .in_is_letter_flag (in_is_letter_flag),
    .in_is_number_flag (in_is_number_flag),
    .in_end_of_text    (in_end_of_text),
    .fq_valid          (fq_valid),
    .fq_pop            (fq_pop),
    .fq_cls            (fq_cls),
    .fq_pos            (fq_pos),
    .fq_eot            (fq_eot)
  );

  bpe_pts_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (split_mode_r),
    .fq_valid  (fq_valid),
    .fq_cls    (fq_cls),
    .fq_pos    (fq_pos),
    .fq_eot    (fq_eot),
    .fq_pop    (fq_pop),
    .oq_count  (oq_count),
    .em_pieces (em_pieces),
    .em_ctl    (em_ctl)
  );

  bpe_pts_outq u_outq (
    .clk              (clk),
    .rst_n            (rst_n),
    .em_pieces        (em_pieces),
    .em_ctl           (em_ctl),
    .oq_count         (oq_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_piece_start  (out_piece_start),
    .out_piece_length (out_piece_length),
    .out_last_piece   (out_last_piece)
  );

endmodule
